// File: rtl/postfix_stack_evaluator_defines.svh
// assertion macros for the postfix stack evaluator checker
`ifndef POSTFIX_STACK_EVALUATOR_DEFINES_SVH
`define POSTFIX_STACK_EVALUATOR_DEFINES_SVH

// clocked assertion, masked while reset is high
`define PSE_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds across reset
`define PSE_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pse_pkg.sv
// types, constants and helpers shared by the postfix stack evaluator
package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int WORD_W      = 8;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 3;
  // power of two, so the queue pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_SLASH = 8'h2f;
  localparam logic [7:0] CHAR_CARET = 8'h5e;

  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COUNT_W-1:0]       count_t;
  typedef logic [QPTR_W-1:0]        qptr_t;
  typedef logic [QCNT_W-1:0]        qcnt_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_UNKNOWN   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_XOR,
    OP_UNKNOWN
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_READ,
    BS_DIV,
    BS_DONE
  } back_state_t;

  function automatic cmd_t classify(input logic [7:0] symbol, input logic last);
    cmd_t c;
    logic [7:0] diff;
    c.op    = OP_UNKNOWN;
    c.digit = 4'd0;
    c.last  = last;
    diff    = symbol - CHAR_ZERO;
    if (symbol >= CHAR_ZERO && symbol <= CHAR_NINE) begin
      c.op    = OP_DIGIT;
      c.digit = diff[3:0];
    end else if (symbol == CHAR_PLUS) begin
      c.op = OP_ADD;
    end else if (symbol == CHAR_MINUS) begin
      c.op = OP_SUB;
    end else if (symbol == CHAR_STAR) begin
      c.op = OP_MUL;
    end else if (symbol == CHAR_SLASH) begin
      c.op = OP_DIV;
    end else if (symbol == CHAR_CARET) begin
      c.op = OP_XOR;
    end
    return c;
  endfunction

endpackage

// File: rtl/pse_sym_if.sv
// input channel: one symbol word per handshake
interface pse_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       end_of_expr;

  modport source (output valid, output symbol, output end_of_expr, input ready);
  modport sink (input valid, input symbol, input end_of_expr, output ready);
endinterface

// File: rtl/pse_res_if.sv
// result channel: one result word per handshake
interface pse_res_if;
  logic                          valid;
  logic                          ready;
  logic signed [7:0]             top_value;
  logic [pse_pkg::COUNT_W-1:0]   stack_count;
  logic [pse_pkg::STATUS_W-1:0]  status;
  logic signed [7:0]             final_value;

  modport source (output valid, output top_value, output stack_count, output status,
                  output final_value, input ready);
  modport sink (input valid, input top_value, input stack_count, input status,
                input final_value, output ready);
endinterface

// File: rtl/pse_ram.sv
// generic single write port ram with registered read
module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pse_front.sv
// front end: accepts symbol words, classifies them and queues commands
module pse_front (
  input  logic            clk,
  input  logic            rst,
  pse_sym_if.sink         symbols,
  output pse_pkg::cmd_t   q_head,
  output logic            q_valid,
  input  logic            q_ready
);

  pse_pkg::cmd_t  slots [pse_pkg::QUEUE_DEPTH];
  pse_pkg::qptr_t wr_ptr;
  pse_pkg::qptr_t rd_ptr;
  pse_pkg::qcnt_t fill;
  logic           push;
  logic           pop;

  assign symbols.ready = (fill != pse_pkg::qcnt_t'(pse_pkg::QUEUE_DEPTH));
  assign push          = symbols.valid && symbols.ready;
  assign q_valid       = (fill != '0);
  assign pop           = q_valid && q_ready;
  assign q_head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= pse_pkg::classify(symbols.symbol, symbols.end_of_expr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + pse_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + pse_pkg::qptr_t'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + pse_pkg::qcnt_t'(1);
        2'b01:   fill <= fill - pse_pkg::qcnt_t'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/pse_div.sv
// signed 8-bit divider, one quotient bit per cycle, truncates toward zero
module pse_div (
  input  logic              clk,
  input  logic              rst,
  input  pse_pkg::div_req_t req,
  output logic              done,
  output pse_pkg::word_t    quotient
);

  logic [pse_pkg::WORD_W-1:0]         rem;
  logic [pse_pkg::WORD_W-1:0]         quo;
  logic [pse_pkg::WORD_W-1:0]         den;
  logic                               neg;
  logic                               active;
  logic [$clog2(pse_pkg::WORD_W)-1:0] step;
  logic [pse_pkg::WORD_W:0]           shifted;
  logic [pse_pkg::WORD_W:0]           den_ext;
  logic [pse_pkg::WORD_W:0]           diff;
  logic                               fits;

  assign shifted  = {rem, quo[pse_pkg::WORD_W-1]};
  assign den_ext  = {1'b0, den};
  assign diff     = shifted - den_ext;
  assign fits     = (shifted >= den_ext);
  // magnitude 128 negates to itself, which is the wrap the stack expects
  assign quotient = neg ? pse_pkg::word_t'(-quo) : pse_pkg::word_t'(quo);

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg  <= req.dividend[pse_pkg::WORD_W-1] ^ req.divisor[pse_pkg::WORD_W-1];
      quo  <= req.dividend[pse_pkg::WORD_W-1] ? -req.dividend : req.dividend;
      den  <= req.divisor[pse_pkg::WORD_W-1] ? -req.divisor : req.divisor;
      rem  <= '0;
    end else if (active) begin
      rem <= fits ? diff[pse_pkg::WORD_W-1:0] : shifted[pse_pkg::WORD_W-1:0];
      quo <= {quo[pse_pkg::WORD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      step   <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == '1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/pse_back.sv
// back end: runs queued commands against the stack and registers each result
module pse_back (
  input  logic          clk,
  input  logic          rst,
  input  pse_pkg::cmd_t q_head,
  input  logic          q_valid,
  output logic          q_ready,
  pse_res_if.source     results
);

  pse_pkg::back_state_t state, state_next;
  pse_pkg::cmd_t        cmd, cmd_next;
  pse_pkg::ptr_t        ptr, ptr_next;
  pse_pkg::word_t       tos, tos_next;
  pse_pkg::word_t       bottom, bottom_next;
  pse_pkg::ptr_t        ptr_new, ptr_new_next;
  pse_pkg::word_t       tos_new, tos_new_next;
  logic                 wr_en, wr_en_next;
  pse_pkg::word_t       wr_data, wr_data_next;
  pse_pkg::status_t     status, status_next;

  pse_pkg::addr_t       rd_addr;
  logic [7:0]           rd_raw;
  pse_pkg::word_t       rd_data;
  logic                 ram_we;
  pse_pkg::div_req_t    div_req;
  logic                 div_done;
  pse_pkg::word_t       div_quot;
  logic                 out_load;
  pse_pkg::word_t       bottom_upd;
  pse_pkg::word_t       alu;

  assign rd_data = pse_pkg::word_t'(rd_raw);

  pse_ram #(
    .WIDTH (pse_pkg::WORD_W),
    .DEPTH (pse_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pse_pkg::addr_t'(ptr_new - pse_pkg::ptr_t'(1))),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  pse_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  // right operand is the cached top, left operand comes from the ram
  always_comb begin
    unique case (cmd.op)
      pse_pkg::OP_ADD: alu = pse_pkg::word_t'(rd_data + tos);
      pse_pkg::OP_SUB: alu = pse_pkg::word_t'(rd_data - tos);
      pse_pkg::OP_MUL: alu = pse_pkg::word_t'(rd_data * tos);
      pse_pkg::OP_XOR: alu = rd_data ^ tos;
      default:         alu = '0;
    endcase
  end

  assign bottom_upd = (wr_en && ptr_new == pse_pkg::ptr_t'(1)) ? wr_data : bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pse_pkg::BS_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    tos     <= tos_next;
    bottom  <= bottom_next;
    ptr_new <= ptr_new_next;
    tos_new <= tos_new_next;
    wr_en   <= wr_en_next;
    wr_data <= wr_data_next;
    status  <= status_next;
  end

  always_comb begin
    state_next       = state;
    cmd_next         = cmd;
    ptr_next         = ptr;
    tos_next         = tos;
    bottom_next      = bottom;
    ptr_new_next     = ptr_new;
    tos_new_next     = tos_new;
    wr_en_next       = wr_en;
    wr_data_next     = wr_data;
    status_next      = status;
    q_ready          = 1'b0;
    ram_we           = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = rd_data;
    div_req.divisor  = tos;
    rd_addr = (q_head.op == pse_pkg::OP_UNKNOWN) ?
              pse_pkg::addr_t'(ptr - pse_pkg::ptr_t'(3)) :
              pse_pkg::addr_t'(ptr - pse_pkg::ptr_t'(2));
    unique case (state)
      pse_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_ready      = 1'b1;
          cmd_next     = q_head;
          ptr_new_next = ptr;
          tos_new_next = (ptr == '0) ? pse_pkg::word_t'(0) : tos;
          wr_en_next   = 1'b0;
          wr_data_next = '0;
          status_next  = pse_pkg::ST_OK;
          state_next   = pse_pkg::BS_DONE;
          if (q_head.op == pse_pkg::OP_DIGIT) begin
            if (ptr >= pse_pkg::ptr_t'(pse_pkg::STACK_DEPTH)) begin
              status_next = pse_pkg::ST_OVERFLOW;
            end else begin
              ptr_new_next = ptr + pse_pkg::ptr_t'(1);
              tos_new_next = pse_pkg::word_t'({4'd0, q_head.digit});
              wr_en_next   = 1'b1;
              wr_data_next = pse_pkg::word_t'({4'd0, q_head.digit});
            end
          end else if (ptr < pse_pkg::ptr_t'(2)) begin
            status_next = pse_pkg::ST_UNDERFLOW;
          end else if (q_head.op == pse_pkg::OP_UNKNOWN) begin
            status_next  = pse_pkg::ST_UNKNOWN;
            ptr_new_next = ptr - pse_pkg::ptr_t'(2);
            tos_new_next = '0;
            if (ptr != pse_pkg::ptr_t'(2)) begin
              state_next = pse_pkg::BS_READ;
            end
          end else begin
            state_next = pse_pkg::BS_READ;
          end
        end
      end
      pse_pkg::BS_READ: begin
        state_next = pse_pkg::BS_DONE;
        if (cmd.op == pse_pkg::OP_UNKNOWN) begin
          tos_new_next = rd_data;
        end else begin
          ptr_new_next = ptr - pse_pkg::ptr_t'(1);
          wr_en_next   = 1'b1;
          if (cmd.op == pse_pkg::OP_DIV) begin
            wr_data_next = '0;
            tos_new_next = '0;
            if (tos == '0) begin
              status_next = pse_pkg::ST_DIV_ZERO;
            end else begin
              div_req.start = 1'b1;
              state_next    = pse_pkg::BS_DIV;
            end
          end else begin
            wr_data_next = alu;
            tos_new_next = alu;
          end
        end
      end
      pse_pkg::BS_DIV: begin
        if (div_done) begin
          wr_data_next = div_quot;
          tos_new_next = div_quot;
          state_next   = pse_pkg::BS_DONE;
        end
      end
      pse_pkg::BS_DONE: begin
        if (!results.valid || results.ready) begin
          out_load    = 1'b1;
          ram_we      = wr_en;
          bottom_next = bottom_upd;
          ptr_next    = cmd.last ? pse_pkg::ptr_t'(0) : ptr_new;
          tos_next    = cmd.last ? pse_pkg::word_t'(0) : tos_new;
          state_next  = pse_pkg::BS_IDLE;
        end
      end
      default: state_next = pse_pkg::BS_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.top_value   <= tos_new;
      results.stack_count <= pse_pkg::count_t'(ptr_new);
      results.status      <= status;
      results.final_value <= (cmd.last && ptr_new != '0) ? bottom_upd :
                             pse_pkg::word_t'(0);
    end
  end

endmodule

// File: rtl/postfix_stack_evaluator.sv
// postfix evaluator top: a digit passes the back end idle and done states, an operator
// on two or more entries also a stack ram read, a division by a non-zero value also the
// one-bit-per-cycle divider; the back end works on one symbol at a time and holds in done
// while a result word stalls; a two-word queue lets input run ahead
// reset (synchronous, active high) empties the stack and the queue; the stack ram is
// not cleared, entries above the stack pointer are never read
module postfix_stack_evaluator (
  input logic        clk,
  input logic        rst,
  pse_sym_if.sink    symbols,
  pse_res_if.source  results
);

  // classified command handed from front to back
  pse_pkg::cmd_t q_head;
  logic          q_valid;
  logic          q_ready;

  // front end: takes a symbol word whenever the queue has room, even while
  // the back end is busy or a result word waits at the output
  pse_front u_front (
    .clk     (clk),
    .rst     (rst),
    .symbols (symbols),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // back end: stack pointer, cached top and bottom, stack ram, divider and
  // the output register; the stack is committed when the result word is loaded
  pse_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_head  (q_head),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .results (results)
  );

endmodule

// File: rtl/pse_checker.sv
// port-level checker for the postfix stack evaluator, bound to the top level
`include "postfix_stack_evaluator_defines.svh"

module pse_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [7:0]            top_value,
  input logic [pse_pkg::COUNT_W-1:0]  stack_count,
  input logic [pse_pkg::STATUS_W-1:0] status
);

  `PSE_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(stack_count) && $stable(status), "result word dropped or changed while stalled")
  `PSE_ASSERT_RST(a_reset_idle, clk, rst |=> !out_valid, "result word valid right after reset")
  `PSE_ASSERT(a_overflow_full, clk, rst, out_valid && status == pse_pkg::ST_OVERFLOW |-> stack_count == pse_pkg::count_t'(pse_pkg::STACK_DEPTH), "overflow reported on a stack that is not full")
  `PSE_ASSERT(a_underflow_short, clk, rst, out_valid && status == pse_pkg::ST_UNDERFLOW |-> stack_count < pse_pkg::count_t'(2), "underflow reported with two or more entries")
  `PSE_ASSERT(a_div_zero_top, clk, rst, out_valid && status == pse_pkg::ST_DIV_ZERO |-> top_value == 8'sd0, "divide by zero did not leave zero on top")

endmodule

bind postfix_stack_evaluator pse_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .top_value   (results.top_value),
  .stack_count (results.stack_count),
  .status      (results.status)
);

// File: test/pse_result_checker.sv
// watches both channels of the postfix evaluator, predicts every result word and compares
module pse_result_checker (
  input  logic clk,
  input  logic rst,
  pse_sym_if   sym_mon,
  pse_res_if   res_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  typedef struct {
    word_t   top_value;
    count_t  stack_count;
    status_t status;
    word_t   final_value;
  } stack_report_t;

  word_t         eval_stack [STACK_DEPTH];
  int unsigned   eval_depth;
  stack_report_t predicted_reports [$];
  int            mismatches;

  // one symbol through the stack, returns the report it should produce
  function automatic stack_report_t evaluate_symbol(input logic [7:0] sym, input logic last);
    stack_report_t rep;
    word_t         lhs;
    word_t         rhs;
    int            a;
    int            b;
    int            res;
    rep.status      = ST_OK;
    rep.top_value   = '0;
    rep.final_value = '0;
    if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
      if (eval_depth >= STACK_DEPTH) begin
        rep.status = ST_OVERFLOW;
      end else begin
        eval_stack[eval_depth] = word_t'(sym - CHAR_ZERO);
        eval_depth++;
      end
    end else if (eval_depth < 2) begin
      rep.status = ST_UNDERFLOW;
    end else begin
      rhs = eval_stack[eval_depth - 1];
      lhs = eval_stack[eval_depth - 2];
      eval_depth -= 2;
      a = lhs;
      b = rhs;
      res = 0;
      case (sym)
        CHAR_PLUS:  res = a + b;
        CHAR_MINUS: res = a - b;
        CHAR_STAR:  res = a * b;
        CHAR_SLASH: begin
          if (b == 0) rep.status = ST_DIV_ZERO;
          else res = a / b;
        end
        CHAR_CARET: res = a ^ b;
        default:    rep.status = ST_UNKNOWN;
      endcase
      if (rep.status != ST_UNKNOWN) begin
        eval_stack[eval_depth] = res[WORD_W-1:0];
        eval_depth++;
      end
    end
    if (eval_depth > 0) rep.top_value = eval_stack[eval_depth - 1];
    rep.stack_count = count_t'(eval_depth);
    if (last) begin
      if (eval_depth > 0) rep.final_value = eval_stack[0];
      eval_depth = 0;
    end
    return rep;
  endfunction

  initial begin
    mismatches  = 0;
    eval_depth  = 0;
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    stack_report_t want;
    if (rst) begin
      eval_depth = 0;
      predicted_reports.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (predicted_reports.size() == 0) begin
          $error("result word with no symbol outstanding");
          mismatches++;
        end else begin
          want = predicted_reports.pop_front();
          if (res_mon.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, res_mon.top_value);
            mismatches++;
          end
          if (res_mon.stack_count !== want.stack_count) begin
            $error("stack_count: expected %0d, got %0d", want.stack_count,
                   res_mon.stack_count);
            mismatches++;
          end
          if (res_mon.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_mon.status);
            mismatches++;
          end
          if (res_mon.final_value !== want.final_value) begin
            $error("final_value: expected %0d, got %0d", want.final_value,
                   res_mon.final_value);
            mismatches++;
          end
        end
      end
      if (sym_mon.valid && sym_mon.ready)
        predicted_reports.push_back(evaluate_symbol(sym_mon.symbol, sym_mon.end_of_expr));
    end
    fail_count  <= mismatches;
    outstanding <= predicted_reports.size();
  end

endmodule

// File: test/tb_top.sv
// top of the postfix evaluator testbench: clock, reset, symbol stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pse_pkg::*;

  // random part stops once this many symbol words have gone in after the directed part
  localparam int RANDOM_WORDS = 1150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pse_sym_if sym_ch ();
  pse_res_if res_ch ();

  int fail_count;
  int outstanding;

  int         sent_words;
  bit         quiet_sender;
  logic [7:0] expr_q [$];

  postfix_stack_evaluator uut (
    .clk     (clk),
    .rst     (rst),
    .symbols (sym_ch),
    .results (res_ch)
  );

  pse_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .sym_mon     (sym_ch),
    .res_mon     (res_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // overall guard: far beyond the slowest legal run (long gaps, long stalls, divides)
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // mostly back to back or short gaps, now and then a long one
  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] digit_char(input int value);
    return CHAR_ZERO + 8'(value);
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CHAR_PLUS;
      1:       return CHAR_MINUS;
      2:       return CHAR_STAR;
      3:       return CHAR_SLASH;
      default: return CHAR_CARET;
    endcase
  endfunction

  // present one symbol word and hold it until the evaluator takes it;
  // valid is left high so the next word can follow on the very next edge
  task automatic send_symbol(input logic [7:0] sym, input logic last);
    int gap;
    gap = quiet_sender ? 0 : gap_length();
    repeat (gap) begin
      sym_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sym_ch.valid       <= 1'b1;
    sym_ch.symbol      <= sym;
    sym_ch.end_of_expr <= last;
    @(posedge clk);
    while (!sym_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  // hold the input off until every predicted result word has been taken
  task automatic wait_drained();
    sym_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // sends the built expression; the last word always closes it so the next starts empty
  task automatic send_expression(input bit scatter_ends);
    logic last;
    for (int i = 0; i < expr_q.size(); i++) begin
      last = (i == expr_q.size() - 1) || (scatter_ends && $urandom_range(0, 3) == 0);
      send_symbol(expr_q[i], last);
    end
  endtask

  // well-formed postfix: digits and operators kept so the stack never underflows,
  // reduced to a single entry at the end
  task automatic build_wellformed();
    int digits_left;
    int depth;
    expr_q.delete();
    digits_left = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 10);
    depth = 0;
    while (digits_left > 0 || depth > 1) begin
      if (depth >= 2 && (digits_left == 0 || $urandom_range(0, 2) == 0)) begin
        expr_q.push_back(random_operator());
        depth--;
      end else begin
        expr_q.push_back(digit_char($urandom_range(0, 9)));
        depth++;
        digits_left--;
      end
    end
  endtask

  // fills the stack to around its depth so that the overflow path gets hit
  task automatic build_deep();
    int fill;
    expr_q.delete();
    fill = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 6);
    repeat (fill) expr_q.push_back(digit_char($urandom_range(0, 9)));
    repeat ($urandom_range(1, 4)) expr_q.push_back(random_operator());
  endtask

  task automatic build_noise();
    expr_q.delete();
    repeat ($urandom_range(1, 8)) expr_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // receiver: long runs with ready high, stalls mostly short, a few long
  initial begin : result_stall
    int run;
    res_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 12);
      res_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      if ($urandom_range(0, 3) != 0) begin
        res_ch.ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int roll;
    int pos;
    int keep;
    int guard;
    sym_ch.valid       = 1'b0;
    sym_ch.symbol      = '0;
    sym_ch.end_of_expr = 1'b0;
    sent_words         = 0;
    quiet_sender       = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: underflow on an empty stack
    send_symbol(CHAR_PLUS, 1'b0);
    // divide by zero pushes a zero
    send_symbol(digit_char(9), 1'b0);
    send_symbol(digit_char(0), 1'b0);
    send_symbol(CHAR_SLASH, 1'b0);
    // xor with the zero left behind
    send_symbol(digit_char(7), 1'b0);
    send_symbol(CHAR_CARET, 1'b0);
    send_symbol(digit_char(3), 1'b0);
    send_symbol(CHAR_MINUS, 1'b0);
    send_symbol(digit_char(2), 1'b0);
    send_symbol(CHAR_STAR, 1'b0);
    // unknown code with one entry is an underflow, with two it pops both
    send_symbol(8'h00, 1'b0);
    send_symbol(digit_char(1), 1'b0);
    send_symbol(8'hff, 1'b0);
    // 8*8 + 8*8 wraps to the most negative value, then divided by minus one
    send_symbol(digit_char(8), 1'b0);
    send_symbol(digit_char(8), 1'b0);
    send_symbol(CHAR_STAR, 1'b0);
    send_symbol(digit_char(8), 1'b0);
    send_symbol(digit_char(8), 1'b0);
    send_symbol(CHAR_STAR, 1'b0);
    send_symbol(CHAR_PLUS, 1'b0);
    send_symbol(digit_char(0), 1'b0);
    send_symbol(digit_char(1), 1'b0);
    send_symbol(CHAR_MINUS, 1'b0);
    send_symbol(CHAR_SLASH, 1'b1);
    // end of expression on an empty stack reports a zero bottom
    send_symbol(8'h00, 1'b1);

    // let everything settle before the random part
    wait_drained();

    sent_words = 0;
    while (sent_words < RANDOM_WORDS) begin
      roll = $urandom_range(0, 99);
      quiet_sender = ($urandom_range(0, 7) == 0);
      if (roll < 70) begin
        build_wellformed();
        // now and then a stray word slipped in or one dropped
        if ($urandom_range(0, 9) == 0) begin
          pos = $urandom_range(0, expr_q.size() - 1);
          if ($urandom_range(0, 1) == 0) expr_q.insert(pos, 8'($urandom_range(0, 255)));
          else if (expr_q.size() > 1) expr_q.delete(pos);
        end
        send_expression(1'b0);
      end else if (roll < 82) begin
        build_noise();
        send_expression(1'b1);
      end else if (roll < 85) begin
        build_deep();
        send_expression(1'b0);
      end else begin
        // expression cut short: closes with operands still waiting
        build_wellformed();
        keep = $urandom_range(1, expr_q.size());
        while (expr_q.size() > keep) void'(expr_q.pop_back());
        send_expression(1'b0);
      end
      if ($urandom_range(0, 39) == 0) wait_drained();
    end

    sym_ch.valid <= 1'b0;
    // the word taken at this edge only shows in the registered count at the next edge
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    // keep watching the result channel before the verdict, so a stray word would be seen
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
